FILE: rtl/ncwp_pkg.sv
// Package for the nearest contact to world position block: beat types and CORDIC constants.
`timescale 1ns / 1ps

package ncwp_pkg;

    // Rotation count requested and the count actually run (arctangent table holds 24 entries)
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEPS_RUN    = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    // Inverse CORDIC gain in Q30
    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    // Datapath widths
    localparam int XY_W = 43;   // CORDIC x and y, 16 guard fraction bits
    localparam int Z_W  = 34;   // residual angle, units of 2^-32 turn

    typedef struct packed {
        logic signed [31:0] observer_x;
        logic signed [31:0] observer_y;
        logic        [15:0] observer_heading;
        logic        [23:0] contact_range;
        logic        [15:0] contact_bearing;
        logic               last_contact;
    } ncwp_in_t;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic        [23:0] nearest_range;
        logic        [15:0] nearest_bearing;
        logic               saturated;
    } ncwp_out_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_lut(input logic [STEP_W-1:0] idx);
        logic [29:0] val;
        unique case (idx)
            5'd0:    val = 30'd536870912;
            5'd1:    val = 30'd316933406;
            5'd2:    val = 30'd167458907;
            5'd3:    val = 30'd85004756;
            5'd4:    val = 30'd42667331;
            5'd5:    val = 30'd21354465;
            5'd6:    val = 30'd10679838;
            5'd7:    val = 30'd5340245;
            5'd8:    val = 30'd2670163;
            5'd9:    val = 30'd1335087;
            5'd10:   val = 30'd667544;
            5'd11:   val = 30'd333772;
            5'd12:   val = 30'd166886;
            5'd13:   val = 30'd83443;
            5'd14:   val = 30'd41722;
            5'd15:   val = 30'd20861;
            5'd16:   val = 30'd10430;
            5'd17:   val = 30'd5215;
            5'd18:   val = 30'd2608;
            5'd19:   val = 30'd1304;
            5'd20:   val = 30'd652;
            5'd21:   val = 30'd326;
            5'd22:   val = 30'd163;
            5'd23:   val = 30'd81;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/nearest_contact_to_world_position.sv
// Top level: nearest contact selection and polar to world conversion with an iterative CORDIC.
`timescale 1ns / 1ps

// Contacts of one scan arrive one beat each; the block keeps the one with the least range
// (ties keep the earlier one) and latches the observer pose from the first beat of the set.
// A beat that is not marked last is taken and yields no result. The beat
// marked last starts the conversion: the gain-correcting multiply, then STEPS_RUN
// micro-rotations on the shared CORDIC rotate unit, one micro-rotation per cycle, then
// a final step to round, turn by the quadrant, add the pose and saturate, which waits
// while the previous result still occupies the output register. The block takes no
// beat during the conversion and takes the next beat as soon as the result sits in
// the output register.
module nearest_contact_to_world_position (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ncwp_pkg::ncwp_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ncwp_pkg::ncwp_out_t m_payload
);
    import ncwp_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MUL    = 2'd1;
    localparam logic [1:0] ST_ITER   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_RUN - 1);

    logic [1:0]               state_reg, state_next;
    logic                     in_set_reg, in_set_next;
    logic [23:0]              best_range_reg, best_range_next;
    logic [15:0]              best_bearing_reg, best_bearing_next;
    logic signed [31:0]       pose_x_reg, pose_x_next;
    logic signed [31:0]       pose_y_reg, pose_y_next;
    logic [15:0]              heading_reg, heading_next;

    logic signed [31:0]       work_x_reg, work_x_next;
    logic signed [31:0]       work_y_reg, work_y_next;
    logic [23:0]              work_range_reg, work_range_next;
    logic [15:0]              work_bearing_reg, work_bearing_next;
    logic [1:0]               quad_reg, quad_next;
    logic signed [XY_W-1:0]   cx_reg, cx_next;
    logic signed [XY_W-1:0]   cy_reg, cy_next;
    logic signed [Z_W-1:0]    cz_reg, cz_next;
    logic [STEP_W-1:0]        step_reg, step_next;

    logic                     m_valid_reg, m_valid_next;
    ncwp_out_t                out_reg, out_next;

    // Combinational helpers
    logic                     s_fire;
    logic                     take_first;
    logic                     better;
    logic [23:0]              sel_range;
    logic [15:0]              sel_bearing;
    logic [15:0]              sel_heading;
    logic [15:0]              abs_angle;
    logic [15:0]              angle_bias;
    logic [1:0]               quad;
    logic [15:0]              resid;
    logic [53:0]              product;
    logic signed [XY_W-1:0]   dx, dy;
    logic signed [Z_W-1:0]    atan_ext;
    logic signed [XY_W:0]     rx_sum, ry_sum;
    logic signed [27:0]       rnd_x, rnd_y;
    logic signed [27:0]       off_x, off_y;
    logic signed [33:0]       sum_x, sum_y;
    logic                     ovf_x, unf_x, ovf_y, unf_y;
    logic                     slot_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;
    assign slot_free = !m_valid_reg || m_ready;

    // Pick the best contact including the current beat
    assign take_first  = !in_set_reg;
    assign better      = take_first || (s_payload.contact_range < best_range_reg);
    assign sel_range   = better ? s_payload.contact_range : best_range_reg;
    assign sel_bearing = better ? s_payload.contact_bearing : best_bearing_reg;
    assign sel_heading = take_first ? s_payload.observer_heading : heading_reg;

    // Split absolute angle into nearest quadrant and signed residual
    assign abs_angle  = sel_bearing + sel_heading;
    assign angle_bias = abs_angle + 16'h2000;
    assign quad       = angle_bias[15:14];
    assign resid      = abs_angle - {quad, 14'd0};

    // Gain correction multiply
    assign product = 54'(work_range_reg) * 54'(KINV_Q30);

    // Shared micro-rotation unit
    assign dx       = cy_reg >>> step_reg;
    assign dy       = cx_reg >>> step_reg;
    assign atan_ext = Z_W'(atan_lut(step_reg));

    // Round half up by 16 bits and turn by the quadrant
    assign rx_sum = (XY_W+1)'(cx_reg) + (XY_W+1)'(32768);
    assign ry_sum = (XY_W+1)'(cy_reg) + (XY_W+1)'(32768);
    assign rnd_x  = 28'(rx_sum >>> 16);
    assign rnd_y  = 28'(ry_sum >>> 16);

    always_comb begin
        unique case (quad_reg)
            2'd0: begin
                off_x = rnd_x;
                off_y = rnd_y;
            end
            2'd1: begin
                off_x = -rnd_y;
                off_y = rnd_x;
            end
            2'd2: begin
                off_x = -rnd_x;
                off_y = -rnd_y;
            end
            default: begin
                off_x = rnd_y;
                off_y = -rnd_x;
            end
        endcase
    end

    // Add the pose and detect clipping
    assign sum_x = 34'(work_x_reg) + 34'(off_x);
    assign sum_y = 34'(work_y_reg) + 34'(off_y);
    assign ovf_x = (sum_x > 34'sd2147483647);
    assign unf_x = (sum_x < -34'sd2147483648);
    assign ovf_y = (sum_y > 34'sd2147483647);
    assign unf_y = (sum_y < -34'sd2147483648);

    // Sequencer and next-state logic
    always_comb begin
        state_next        = state_reg;
        in_set_next       = in_set_reg;
        best_range_next   = best_range_reg;
        best_bearing_next = best_bearing_reg;
        pose_x_next       = pose_x_reg;
        pose_y_next       = pose_y_reg;
        heading_next      = heading_reg;
        work_x_next       = work_x_reg;
        work_y_next       = work_y_reg;
        work_range_next   = work_range_reg;
        work_bearing_next = work_bearing_reg;
        quad_next         = quad_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        cz_next           = cz_reg;
        step_next         = step_reg;
        m_valid_next      = m_valid_reg;
        out_next          = out_reg;

        // Drop the result once the sink takes the beat
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    best_bearing_next = sel_bearing;
                    if (take_first) begin
                        pose_x_next  = s_payload.observer_x;
                        pose_y_next  = s_payload.observer_y;
                        heading_next = s_payload.observer_heading;
                    end
                    if (s_payload.last_contact) begin
                        // Close the set and hand the winner to the converter
                        in_set_next       = 1'b0;
                        best_range_next   = 24'hFFFFFF;
                        work_x_next       = take_first ? s_payload.observer_x : pose_x_reg;
                        work_y_next       = take_first ? s_payload.observer_y : pose_y_reg;
                        work_range_next   = sel_range;
                        work_bearing_next = sel_bearing;
                        quad_next         = quad;
                        cz_next           = Z_W'({{(Z_W-32){resid[15]}}, resid, 16'd0});
                        state_next        = ST_MUL;
                    end else begin
                        in_set_next     = 1'b1;
                        best_range_next = sel_range;
                    end
                end
            end
            ST_MUL: begin
                cx_next    = XY_W'(product[53:14]);
                cy_next    = '0;
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                // Rotate toward zero residual
                if (!cz_reg[Z_W-1]) begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_ext;
                end else begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_ext;
                end
                if (step_reg == LAST_STEP) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default: begin
                // Hold until the output register is free
                if (slot_free) begin
                    if (ovf_x) begin
                        out_next.target_x = 32'sh7FFFFFFF;
                    end else if (unf_x) begin
                        out_next.target_x = 32'sh80000000;
                    end else begin
                        out_next.target_x = sum_x[31:0];
                    end
                    if (ovf_y) begin
                        out_next.target_y = 32'sh7FFFFFFF;
                    end else if (unf_y) begin
                        out_next.target_y = 32'sh80000000;
                    end else begin
                        out_next.target_y = sum_y[31:0];
                    end
                    out_next.nearest_range   = work_range_reg;
                    out_next.nearest_bearing = work_bearing_reg;
                    out_next.saturated       = ovf_x || unf_x || ovf_y || unf_y;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_set_reg     <= 1'b0;
            best_range_reg <= 24'hFFFFFF;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_set_reg     <= in_set_next;
            best_range_reg <= best_range_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        best_bearing_reg <= best_bearing_next;
        pose_x_reg       <= pose_x_next;
        pose_y_reg       <= pose_y_next;
        heading_reg      <= heading_next;
        work_x_reg       <= work_x_next;
        work_y_reg       <= work_y_next;
        work_range_reg   <= work_range_next;
        work_bearing_reg <= work_bearing_next;
        quad_reg         <= quad_next;
        cx_reg           <= cx_next;
        cy_reg           <= cy_next;
        cz_reg           <= cz_next;
        step_reg         <= step_next;
        out_reg          <= out_next;
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the nearest contact to world position block.
`timescale 1ns / 1ps

module testbench;
    import ncwp_pkg::*;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam longint ARCTAN_TURN32 [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam longint GAIN_INV_Q30 = 64'd652032874;
    localparam longint COORD_MAX    = 64'sd2147483647;
    localparam longint COORD_MIN    = -64'sd2147483648;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     MAX_REPORTS  = 10;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ncwp_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ncwp_out_t m_payload;

    nearest_contact_to_world_position u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #1 aclk = ~aclk;

    ncwp_in_t  scan_beats[$];
    ncwp_out_t pending_targets[$];
    ncwp_out_t want_target;

    int beats_taken   = 0;
    int stim_total    = 0;
    int targets_seen  = 0;
    int clipped_seen  = 0;
    int fault_count   = 0;

    // Append a beat to the tail of the stimulus queue
    function automatic void add_scan_beat(input ncwp_in_t beat);
        scan_beats.insert(scan_beats.size(), beat);
    endfunction

    // Append an expected result to the tail of the scoreboard queue
    function automatic void add_pending_target(input ncwp_out_t want);
        pending_targets.insert(pending_targets.size(), want);
    endfunction

    // Shadow copy of the selection state
    logic [23:0]        best_range   = '1;
    logic [15:0]        best_bearing = '0;
    logic signed [31:0] scan_pose_x  = '0;
    logic signed [31:0] scan_pose_y  = '0;
    logic [15:0]        scan_heading = '0;
    logic               scan_open    = 1'b0;

    // Rotate range along a binary angle: quadrant turn plus CORDIC on the residual
    function automatic void polar_to_offset(input logic [23:0] rng, input logic [15:0] ang,
                                            output longint off_x, output longint off_y);
        logic [16:0] ang_sum;
        logic [1:0]  quad;
        logic [15:0] resid;
        logic [63:0] prod;
        longint      x, y, z, dx, dy, cx, cy;
        ang_sum = {1'b0, ang} + 17'h2000;
        quad    = ang_sum[15:14];
        resid   = ang - {quad, 14'b0};
        z       = longint'($signed(resid)) * 65536;
        prod    = 64'(rng) * GAIN_INV_Q30;
        x       = longint'(prod >> 14);
        y       = 0;
        for (int i = 0; i < STEPS_RUN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_TURN32[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_TURN32[i];
            end
        end
        cx = (x + 32768) >>> 16;
        cy = (y + 32768) >>> 16;
        case (quad)
            2'd0: begin off_x = cx;  off_y = cy;  end
            2'd1: begin off_x = -cy; off_y = cx;  end
            2'd2: begin off_x = -cx; off_y = -cy; end
            default: begin off_x = cy; off_y = -cx; end
        endcase
    endfunction

    // Track the nearest contact of the scan; on the last beat queue its world position
    task automatic predict_nearest_target(input ncwp_in_t beat);
        longint      off_x, off_y, sum_x, sum_y;
        logic [15:0] abs_angle;
        ncwp_out_t   want;
        if (!scan_open) begin
            scan_pose_x  = beat.observer_x;
            scan_pose_y  = beat.observer_y;
            scan_heading = beat.observer_heading;
            best_range   = beat.contact_range;
            best_bearing = beat.contact_bearing;
            scan_open    = 1'b1;
        end else if (beat.contact_range < best_range) begin
            best_range   = beat.contact_range;
            best_bearing = beat.contact_bearing;
        end
        if (beat.last_contact) begin
            abs_angle = best_bearing + scan_heading;
            polar_to_offset(best_range, abs_angle, off_x, off_y);
            sum_x = longint'(scan_pose_x) + off_x;
            sum_y = longint'(scan_pose_y) + off_y;
            want.saturated = 1'b0;
            if (sum_x > COORD_MAX) begin
                sum_x = COORD_MAX;
                want.saturated = 1'b1;
            end else if (sum_x < COORD_MIN) begin
                sum_x = COORD_MIN;
                want.saturated = 1'b1;
            end
            if (sum_y > COORD_MAX) begin
                sum_y = COORD_MAX;
                want.saturated = 1'b1;
            end else if (sum_y < COORD_MIN) begin
                sum_y = COORD_MIN;
                want.saturated = 1'b1;
            end
            want.target_x        = sum_x[31:0];
            want.target_y        = sum_y[31:0];
            want.nearest_range   = best_range;
            want.nearest_bearing = best_bearing;
            add_pending_target(want);
            best_range = '1;
            scan_open  = 1'b0;
        end
    endtask

    function automatic ncwp_in_t make_beat(input logic [31:0] px, input logic [31:0] py,
                                           input logic [15:0] hdg, input logic [23:0] rng,
                                           input logic [15:0] brg, input logic last);
        ncwp_in_t beat;
        beat.observer_x       = px;
        beat.observer_y       = py;
        beat.observer_heading = hdg;
        beat.contact_range    = rng;
        beat.contact_bearing  = brg;
        beat.last_contact     = last;
        return beat;
    endfunction

    // Idle percentage for the current traffic phase, stepped by progress through the stimulus
    function automatic int idle_pct(input bit sender);
        int phase;
        phase = (stim_total == 0) ? 0 : (beats_taken * 4) / stim_total;
        case (phase)
            0: return 0;
            1: return sender ? 79 : 0;
            2: return sender ? 0 : 79;
            default: return 17;
        endcase
    endfunction

    // Fill the scan queue: directed corners first, then random scans
    initial begin : fill_scans
        int          set_len;
        logic [31:0] px, py;
        logic [15:0] hdg;
        logic [23:0] rng;

        // Zero range, then full range on and just below a quadrant boundary
        add_scan_beat(make_beat(0, 0, 16'h0000, 24'h000000, 16'h0000, 1'b1));
        add_scan_beat(make_beat(0, 0, 16'h0000, 24'hFFFFFF, 16'h2000, 1'b1));
        add_scan_beat(make_beat(0, 0, 16'h0000, 24'hFFFFFF, 16'h1FFF, 1'b1));
        // Equal ranges keep the earlier contact; heading plus bearing wraps past a turn
        add_scan_beat(make_beat(1000, -1000, 16'hF000, 24'd300, 16'h1111, 1'b0));
        add_scan_beat(make_beat(-5, 7, 16'h0123, 24'd300, 16'h2222, 1'b0));
        add_scan_beat(make_beat(9, 9, 16'h4567, 24'd300, 16'h3333, 1'b1));
        // A later, smaller contact wins; the last beat itself is the winner
        add_scan_beat(make_beat(256, 512, 16'h4000, 24'h800000, 16'hABCD, 1'b0));
        add_scan_beat(make_beat(0, 0, 16'h0000, 24'h000100, 16'h5555, 1'b0));
        add_scan_beat(make_beat(0, 0, 16'h0000, 24'h000050, 16'hFFFF, 1'b1));
        // Clip each coordinate at both limits
        add_scan_beat(make_beat(32'h7FFFFFFF, 0, 16'h0000, 24'hFFFFFF, 16'h0000, 1'b1));
        add_scan_beat(make_beat(32'h80000000, 0, 16'h8000, 24'hFFFFFF, 16'h0000, 1'b1));
        add_scan_beat(make_beat(0, 32'h7FFFFFFF, 16'h0000, 24'hFFFFFF, 16'h4000, 1'b1));
        add_scan_beat(make_beat(0, 32'h80000000, 16'h0000, 24'hFFFFFF, 16'hC000, 1'b1));
        // At the limit but pointing inward: no clipping
        add_scan_beat(make_beat(32'h7FFFFFFF, 32'h80000000, 16'h0000, 24'hFFFFFF,
                                16'h6000, 1'b1));
        // Remaining quadrant boundaries and heading wrap
        add_scan_beat(make_beat(0, 0, 16'hFFFF, 24'h123456, 16'h6000, 1'b1));
        add_scan_beat(make_beat(0, 0, 16'h0001, 24'h000001, 16'hA000, 1'b1));
        add_scan_beat(make_beat(-1, -1, 16'h0000, 24'h00FF00, 16'hE000, 1'b1));

        // Random scans of one to six contacts, some with the pose near a limit
        while (scan_beats.size() < 520) begin
            set_len = $urandom_range(1, 6);
            px  = $urandom;
            py  = $urandom;
            hdg = 16'($urandom);
            rng = 24'($urandom);
            case ($urandom_range(7))
                0: px = 32'h7FFFFFFF - $urandom_range(0, 32'h01000000);
                1: px = 32'h80000000 + $urandom_range(0, 32'h01000000);
                2: py = 32'h7FFFFFFF - $urandom_range(0, 32'h01000000);
                3: py = 32'h80000000 + $urandom_range(0, 32'h01000000);
                default: ;
            endcase
            for (int j = 0; j < set_len; j++) begin
                case ($urandom_range(3))
                    0: rng = 24'($urandom);
                    1: rng = 24'($urandom_range(255));
                    2: ;
                    default: rng = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                endcase
                add_scan_beat(make_beat(px, py, hdg, rng, 16'($urandom), j == set_len - 1));
                // Pose on later beats is ignored by the block; vary it anyway
                px  = $urandom;
                py  = $urandom;
                hdg = 16'($urandom);
            end
        end
        stim_total = scan_beats.size();
    end

    // Driver: hold a beat until accepted, then offer the next or go idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_nearest_target(s_payload);
                beats_taken++;
            end
            if (!s_valid || s_ready) begin
                if (scan_beats.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    s_payload <= scan_beats.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest expected target
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_targets.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("unexpected result beat: x=%0d y=%0d range=%h bearing=%h sat=%b",
                                 m_payload.target_x, m_payload.target_y,
                                 m_payload.nearest_range, m_payload.nearest_bearing,
                                 m_payload.saturated);
                end else begin
                    want_target = pending_targets.pop_front();
                    targets_seen++;
                    if (want_target.saturated)
                        clipped_seen++;
                    if (m_payload.target_x !== want_target.target_x ||
                        m_payload.target_y !== want_target.target_y ||
                        m_payload.nearest_range !== want_target.nearest_range ||
                        m_payload.nearest_bearing !== want_target.nearest_bearing ||
                        m_payload.saturated !== want_target.saturated) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS) begin
                            $display("target %0d mismatch: want x=%0d y=%0d range=%h bearing=%h sat=%b",
                                     targets_seen, want_target.target_x, want_target.target_y,
                                     want_target.nearest_range, want_target.nearest_bearing,
                                     want_target.saturated);
                            $display("                     got x=%0d y=%0d range=%h bearing=%h sat=%b",
                                     m_payload.target_x, m_payload.target_y,
                                     m_payload.nearest_range, m_payload.nearest_bearing,
                                     m_payload.saturated);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // Reset, then wait for all beats to go in and all targets to come out
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (scan_beats.size() != 0 || s_valid || pending_targets.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d contact beats in %0d scans, %0d with clipped coordinates",
                 beats_taken, targets_seen, clipped_seen);
        $display("failures: %0d", fault_count);
        if (fault_count == 0 && pending_targets.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
